### src/sia_pkg.sv
package sia_pkg;

	localparam int CAPACITY_DEF = 64;
	// wide enough for a fill count at the largest supported capacity
	localparam int CNT_W = 11;

	localparam logic [2:0] CMD_SET    = 3'd0;
	localparam logic [2:0] CMD_GET    = 3'd1;
	localparam logic [2:0] CMD_INS_AT = 3'd2;
	localparam logic [2:0] CMD_INS_ORD = 3'd3;
	localparam logic [2:0] CMD_PUSH_F = 3'd4;
	localparam logic [2:0] CMD_PUSH_B = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic [2:0] OP_NOP    = 3'd0;
	localparam logic [2:0] OP_WRITE  = 3'd1;
	localparam logic [2:0] OP_READ   = 3'd2;
	localparam logic [2:0] OP_INSERT = 3'd3;
	localparam logic [2:0] OP_ORDER  = 3'd4;

	typedef struct packed {
		logic [2:0]         command;
		logic [5:0]         index;
		logic signed [63:0] value;
	} req_t;

	typedef struct packed {
		logic signed [63:0] read_value;
		logic [6:0]         fill_count;
		logic [5:0]         position;
		logic [1:0]         status;
	} rsp_t;

	// wavefront moving along the cell row
	typedef struct packed {
		logic               active;
		logic [2:0]         op;
		logic [CNT_W-1:0]   target;
		logic [CNT_W-1:0]   cnt;
		logic signed [63:0] value;
		logic signed [63:0] carry;
		logic               shifting;
		logic signed [63:0] rd;
	} tok_t;

endpackage

### src/sia_cell.sv
module sia_cell import sia_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  tok_t tok_in,
	output tok_t tok_out
);

	localparam logic [CNT_W-1:0] MY = CNT_W'(IDX);

	logic signed [63:0] slot_q;
	logic signed [63:0] slot_d;
	tok_t               tok_q;
	tok_t               tok_d;
	logic               in_fill;
	logic               at_fill;
	logic               start;

	always_comb begin
		tok_d   = tok_in;
		slot_d  = slot_q;
		in_fill = MY < tok_in.cnt;
		at_fill = MY == tok_in.cnt;
		start   = 1'b0;
		if (tok_in.active) begin
			case (tok_in.op)
				OP_WRITE: begin
					if (MY == tok_in.target)
						slot_d = tok_in.value;
				end
				OP_READ: begin
					if (MY == tok_in.target)
						tok_d.rd = slot_q;
				end
				OP_INSERT, OP_ORDER: begin
					if (tok_in.op == OP_INSERT)
						start = !tok_in.shifting && (MY == tok_in.target);
					else
						start = !tok_in.shifting &&
							(in_fill ? ($signed(slot_q) > $signed(tok_in.value)) : at_fill);
					if (start) begin
						slot_d         = tok_in.value;
						tok_d.carry    = slot_q;
						tok_d.shifting = 1'b1;
						tok_d.target   = MY;
					end else if (tok_in.shifting) begin
						if (in_fill || at_fill) begin
							slot_d      = tok_in.carry;
							tok_d.carry = slot_q;
						end else begin
							tok_d.shifting = 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			tok_q  <= '0;
		end else begin
			slot_q <= slot_d;
			tok_q  <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule

### src/sorted_insert_array.sv
// Fixed-capacity array of signed 64-bit slots with a fill count.
// Request channel: req_valid / req_ready carrying req (command, index, value).
// Response channel: rsp_valid / rsp_ready carrying rsp (read_value,
// fill_count, position, status). Exactly one response per request.
// Each slot lives in its own cell; a request travels down the row of
// CAPACITY cells as a wavefront, one cell per cycle, which does the write,
// read, ordered search and shift-up on its way. The request is registered,
// passes through every cell register and is then registered in the output
// register; only one request is in the row at a time.
// req_ready drops while a request is in the row.
// A finished response waits in the output register; a new request is still
// taken then. If that request finishes while the receiver keeps stalling,
// its response parks in a hold register and req_ready stays low until the
// output frees up.
// Reset clears every slot to zero, the fill count, and the valid flags of both registers.
module sorted_insert_array import sia_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0] used_q;
	logic          busy_q;
	logic [1:0]    status_q;
	logic [CW-1:0] cnt_new_q;
	logic [CW-1:0] pos_q;
	logic          order_q;
	tok_t          issue_q;
	tok_t          chain [CAPACITY+1];
	rsp_t          res;
	rsp_t          out_q;
	logic          out_valid_q;
	rsp_t          pend_q;
	logic          pend_valid_q;

	logic          accept;
	logic          idx_ok;
	logic          full;
	logic [CW-1:0] idx_c;
	logic [CW-1:0] cnt_d;
	logic [CW-1:0] pos_d;
	logic [1:0]    status_d;
	logic [2:0]    op_d;
	logic [CW-1:0] target_d;
	logic          done;
	logic          out_free;

	assign accept   = req_valid && req_ready;
	assign req_ready = !busy_q && !pend_valid_q;
	assign idx_ok   = 32'(req.index) < CAPACITY;
	assign full     = 32'(used_q) >= CAPACITY;
	assign idx_c    = CW'(req.index);

	always_comb begin
		cnt_d    = used_q;
		pos_d    = '0;
		status_d = ST_OK;
		op_d     = OP_NOP;
		target_d = idx_c;
		case (req.command)
			CMD_SET: begin
				if (!idx_ok) begin
					status_d = ST_RANGE;
				end else begin
					op_d  = OP_WRITE;
					pos_d = idx_c;
					if (idx_c + 1'b1 > used_q)
						cnt_d = idx_c + 1'b1;
				end
			end
			CMD_GET: begin
				if (!idx_ok) begin
					status_d = ST_RANGE;
				end else begin
					op_d  = OP_READ;
					pos_d = idx_c;
				end
			end
			CMD_INS_AT: begin
				if (!idx_ok) begin
					status_d = ST_RANGE;
				end else if (idx_c >= used_q) begin
					op_d  = OP_WRITE;
					pos_d = idx_c;
					cnt_d = idx_c + 1'b1;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					op_d  = OP_INSERT;
					pos_d = idx_c;
					cnt_d = used_q + 1'b1;
				end
			end
			CMD_INS_ORD, CMD_PUSH_F, CMD_PUSH_B: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					cnt_d = used_q + 1'b1;
					if (req.command == CMD_INS_ORD) begin
						op_d = OP_ORDER;
					end else if (req.command == CMD_PUSH_F) begin
						op_d     = OP_INSERT;
						target_d = '0;
					end else begin
						op_d     = OP_INSERT;
						target_d = used_q;
						pos_d    = used_q;
					end
				end
			end
			default: begin
				status_d = ST_RANGE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			busy_q    <= 1'b0;
			issue_q   <= '0;
			status_q  <= ST_OK;
			cnt_new_q <= '0;
			pos_q     <= '0;
			order_q   <= 1'b0;
		end else begin
			issue_q.active <= accept;
			if (accept) begin
				used_q           <= cnt_d;
				busy_q           <= 1'b1;
				status_q         <= status_d;
				cnt_new_q        <= cnt_d;
				pos_q            <= pos_d;
				order_q          <= (op_d == OP_ORDER);
				issue_q.op       <= op_d;
				issue_q.target   <= CNT_W'(target_d);
				issue_q.cnt      <= CNT_W'(used_q);
				issue_q.value    <= req.value;
				issue_q.carry    <= '0;
				issue_q.shifting <= 1'b0;
				issue_q.rd       <= '0;
			end else if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign chain[0] = issue_q;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		sia_cell #(
			.IDX(i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tok_in (chain[i]),
			.tok_out(chain[i+1])
		);
	end

	assign done = chain[CAPACITY].active;

	always_comb begin
		res.read_value = chain[CAPACITY].rd;
		res.fill_count = 7'(cnt_new_q);
		res.position   = order_q ? chain[CAPACITY].target[5:0] : 6'(pos_q);
		res.status     = status_q;
	end

	assign out_free = !out_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (done) begin
				if (out_free) begin
					out_valid_q <= 1'b1;
				end else begin
					pend_valid_q <= 1'b1;
				end
			end else if (pend_valid_q && out_free) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			if (out_free)
				out_q <= res;
			else
				pend_q <= res;
		end else if (pend_valid_q && out_free) begin
			out_q <= pend_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

### tb/sv/sia_checker.sv
`timescale 1ns / 100ps

module sia_checker import sia_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic       req_ready,
	input  req_t       req,
	input  logic       rsp_valid,
	input  logic       rsp_ready,
	input  rsp_t       rsp,
	output int         fail_count,
	output int         pending,
	output logic [6:0] fill,
	output int         checked,
	output int         full_seen,
	output int         range_seen
);

	logic signed [63:0] slot_mem [CAPACITY];
	int                 used;
	rsp_t               expected_rsp_q[$];
	int                 errs;
	int                 n_checked;
	int                 n_full;
	int                 n_range;

	// open slot p by moving used entries up one, then write v there
	function automatic void shift_in(input int p, input logic signed [63:0] v);
		for (int i = used; i > p; i--)
			slot_mem[i] = slot_mem[i - 1];
		slot_mem[p] = v;
		used++;
	endfunction

	function automatic rsp_t execute(input req_t r);
		rsp_t o;
		int   idx;
		int   p;
		o = '0;
		idx = int'(r.index);
		case (r.command)
			CMD_SET, CMD_GET: begin
				if (idx >= CAPACITY) begin
					o.status = ST_RANGE;
				end else if (r.command == CMD_SET) begin
					slot_mem[idx] = r.value;
					if (idx + 1 > used)
						used = idx + 1;
					o.position = r.index;
				end else begin
					o.read_value = slot_mem[idx];
					o.position = r.index;
				end
			end
			CMD_INS_AT: begin
				if (idx >= CAPACITY) begin
					o.status = ST_RANGE;
				end else if (idx >= used) begin
					slot_mem[idx] = r.value;
					used = idx + 1;
					o.position = r.index;
				end else if (used >= CAPACITY) begin
					o.status = ST_FULL;
				end else begin
					shift_in(idx, r.value);
					o.position = r.index;
				end
			end
			CMD_INS_ORD, CMD_PUSH_F, CMD_PUSH_B: begin
				if (used >= CAPACITY) begin
					o.status = ST_FULL;
				end else begin
					if (r.command == CMD_PUSH_F) begin
						p = 0;
					end else if (r.command == CMD_PUSH_B) begin
						p = used;
					end else begin
						// equal entries stay below the new value
						p = 0;
						while (p < used && !(slot_mem[p] > $signed(r.value)))
							p++;
					end
					shift_in(p, r.value);
					o.position = 6'(p);
				end
			end
			default: begin
				o.status = ST_RANGE;
			end
		endcase
		o.fill_count = 7'(used);
		return o;
	endfunction

	always @(posedge clk) begin : watch
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < CAPACITY; i++)
				slot_mem[i] = '0;
			used = 0;
			expected_rsp_q.delete();
			errs = 0;
			n_checked = 0;
			n_full = 0;
			n_range = 0;
		end else begin
			if (req_valid && req_ready)
				expected_rsp_q.push_back(execute(req));
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp_q.size() == 0) begin
					errs++;
					$display("%0t: response with no request outstanding: %p", $time, rsp);
				end else begin
					want = expected_rsp_q.pop_front();
					n_checked++;
					if (want.status == ST_FULL)
						n_full++;
					if (want.status == ST_RANGE)
						n_range++;
					if (rsp.read_value !== want.read_value) begin
						errs++;
						$display("%0t: read_value expected %0d actual %0d", $time,
							want.read_value, rsp.read_value);
					end
					if (rsp.fill_count !== want.fill_count) begin
						errs++;
						$display("%0t: fill_count expected %0d actual %0d", $time,
							want.fill_count, rsp.fill_count);
					end
					if (rsp.position !== want.position) begin
						errs++;
						$display("%0t: position expected %0d actual %0d", $time,
							want.position, rsp.position);
					end
					if (rsp.status !== want.status) begin
						errs++;
						$display("%0t: status expected %0d actual %0d", $time,
							want.status, rsp.status);
					end
				end
			end
		end
		fail_count <= errs;
		pending <= expected_rsp_q.size();
		fill <= 7'(used);
		checked <= n_checked;
		full_seen <= n_full;
		range_seen <= n_range;
	end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import sia_pkg::*;

	localparam int CAP       = CAPACITY_DEF;
	localparam int N_RANDOM  = 400;
	localparam int LIMIT     = 400000;
	localparam int IDLE_PCT  = 38;
	localparam int CALM_FROM = 4000;
	localparam int CALM_TO   = 9000;
	localparam int HOLD_AT   = 12000;
	localparam int HOLD_LEN  = 600;

	// command codes the block does not define
	localparam logic [2:0] CMD_BAD_LO = 3'd6;
	localparam logic [2:0] CMD_BAD_HI = 3'd7;

	localparam logic signed [63:0] VMIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] VMAX = 64'sh7fff_ffff_ffff_ffff;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_ready;
	req_t       req = '0;
	logic       rsp_valid;
	logic       rsp_ready = 1'b0;
	rsp_t       rsp;

	int         fail_count;
	int         pending;
	logic [6:0] fill;
	int         checked;
	int         full_seen;
	int         range_seen;

	int         cycle_cnt = 0;
	int         hold_left = 0;
	int         input_stalls = 0;
	int         n_sent = 0;

	wire calm = (cycle_cnt >= CALM_FROM) && (cycle_cnt < CALM_TO);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sorted_insert_array #(.CAPACITY(CAP)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	sia_checker #(.CAPACITY(CAP)) u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending),
		.fill       (fill),
		.checked    (checked),
		.full_seen  (full_seen),
		.range_seen (range_seen)
	);

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (hold_left > 0 && req_valid && !req_ready)
			input_stalls <= input_stalls + 1;
		if (cycle_cnt >= LIMIT) begin
			$display("Timed out after %0d cycles, %0d responses outstanding", cycle_cnt, pending);
			$display("Regression FAIL");
			$finish;
		end
	end

	// response side: random stalls, a calm window, and one long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (hold_left > 0) begin
			rsp_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (cycle_cnt == HOLD_AT) begin
			rsp_ready <= 1'b0;
			hold_left <= HOLD_LEN - 1;
		end else if (calm) begin
			rsp_ready <= 1'b1;
		end else begin
			rsp_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	function automatic req_t mk(input logic [2:0] c, input logic [5:0] i,
		input logic [63:0] v);
		req_t r;
		r.command = c;
		r.index = i;
		r.value = v;
		return r;
	endfunction

	function automatic logic [63:0] pick_value();
		logic [63:0] v;
		case ($urandom_range(0, 9))
			0: v = VMIN;
			1: v = VMAX;
			2: v = '0;
			3: v = '1;
			4, 5, 6: v = 64'($urandom_range(0, 8)) - 64'd4;
			default: v = {$urandom, $urandom};
		endcase
		return v;
	endfunction

	function automatic req_t rand_req();
		int         r;
		int         f;
		int         lo;
		int         hi;
		logic [2:0] c;
		logic [5:0] ix;
		f = int'(fill);
		r = $urandom_range(0, 99);
		if (r < 46)
			c = CMD_GET;
		else if (r < 66)
			c = CMD_SET;
		else if (r < 78)
			c = CMD_INS_ORD;
		else if (r < 84)
			c = CMD_INS_AT;
		else if (r < 88)
			c = CMD_PUSH_F;
		else if (r < 92)
			c = CMD_PUSH_B;
		else if (r < 96)
			c = CMD_BAD_LO;
		else
			c = CMD_BAD_HI;
		lo = (f > CAP - 1) ? CAP - 1 : f;
		hi = (f + 3 > CAP - 1) ? CAP - 1 : f + 3;
		if (c == CMD_GET) begin
			if (f > 0 && $urandom_range(0, 99) < 75)
				ix = 6'($urandom_range(0, f - 1));
			else
				ix = 6'($urandom_range(0, CAP - 1));
		end else if (c == CMD_SET || c == CMD_INS_AT) begin
			// mostly inside the used range, sometimes just past it
			if (f > 0 && $urandom_range(0, 99) < 85)
				ix = 6'($urandom_range(0, f - 1));
			else
				ix = 6'($urandom_range(lo, hi));
		end else begin
			ix = 6'($urandom);
		end
		return mk(c, ix, pick_value());
	endfunction

	task automatic offer(input req_t r);
		int gap;
		gap = 0;
		if (!calm && hold_left == 0)
			gap = $urandom_range(0, 80);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		n_sent++;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unwritten slots, unknown commands, then build a short unsorted row
		offer(mk(CMD_GET, 6'd63, VMAX));
		offer(mk(CMD_GET, 6'd0, VMIN));
		offer(mk(CMD_BAD_LO, 6'd63, VMAX));
		offer(mk(CMD_BAD_HI, 6'd0, '1));
		offer(mk(CMD_PUSH_B, 6'd0, VMIN));
		offer(mk(CMD_PUSH_F, 6'd63, VMAX));
		offer(mk(CMD_INS_ORD, 6'd0, '0));
		offer(mk(CMD_INS_ORD, 6'd0, '0));
		offer(mk(CMD_INS_ORD, 6'd0, VMIN));
		offer(mk(CMD_INS_ORD, 6'd0, VMAX));
		offer(mk(CMD_INS_ORD, 6'd0, '1));
		offer(mk(CMD_SET, 6'd2, 64'h5555_5555_5555_5555));
		offer(mk(CMD_INS_AT, 6'd0, 64'haaaa_aaaa_aaaa_aaaa));
		offer(mk(CMD_INS_AT, 6'd20, 64'hffff_ffff_ffff_fffe));
		offer(mk(CMD_GET, 6'd15, '0));
		offer(mk(CMD_GET, 6'd20, '0));
		offer(mk(CMD_SET, 6'd25, 64'd1));
		offer(mk(CMD_GET, 6'd23, '0));
		offer(mk(CMD_GET, 6'd1, '0));
		offer(mk(CMD_PUSH_B, 6'd0, '0));
		offer(mk(CMD_INS_AT, 6'd3, VMAX));
		offer(mk(CMD_SET, 6'd0, VMIN));

		for (int n = 0; n < N_RANDOM; n++)
			offer(rand_req());

		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (CAP + 10) @(posedge clk);

		$display("Sent %0d requests, checked %0d responses: %0d full, %0d range/unknown, fill %0d.",
			n_sent, checked, full_seen, range_seen, fill);
		$display("Output hold-off of %0d cycles stalled the input for %0d cycles.",
			HOLD_LEN, input_stalls);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### filelist.f
src/sia_pkg.sv
src/sia_cell.sv
src/sorted_insert_array.sv
tb/sv/sia_checker.sv
tb/sv/tb_top.sv
